/* rtl/gbnrc_pkg.sv */
// shared types, constants and checksum helpers for the go-back-n receiver
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package gbnrc_pkg;

    localparam int HEADER_WORDS = 6;
    localparam int POS_W        = $clog2(HEADER_WORDS + 1);
    localparam int WORD_W       = 16;

    // header word positions
    localparam int HDR_ACK   = 0;
    localparam int HDR_SEQ   = 1;
    localparam int HDR_LEN   = 2;
    localparam int HDR_FLAGS = 4;
    localparam int HDR_TAG   = 5;

    localparam logic [WORD_W-1:0] TAG_DATA    = 16'd3;
    localparam logic [WORD_W-1:0] FLAG_END    = 16'd4;
    localparam logic [WORD_W-1:0] FLAG_RESEND = 16'd1;
    localparam logic [WORD_W-1:0] SUM_GOOD    = 16'hffff;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_OOO      = 3'd1,
        VERDICT_CSUM_ERR = 3'd2,
        VERDICT_NOT_DATA = 3'd3,
        VERDICT_CLOSED   = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_in_item;

    typedef struct packed {
        t_verdict          verdict;
        logic [WORD_W-1:0] reply_ack;
        logic [WORD_W-1:0] reply_seq;
        logic [WORD_W-1:0] reply_flag;
        logic [WORD_W-1:0] reply_checksum;
        logic              send_reply;
        logic [WORD_W-1:0] payload_length;
        logic              transfer_done;
    } t_out_item;

    // one's-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? (s[WORD_W-1:0] + 16'd1) : s[WORD_W-1:0];
    endfunction

    // inverted one's-complement sum over ack, seq, 0, 0, flag, tag
    // plain sum then two carry folds; tag is nonzero so the fold never gives zero
    function automatic logic [WORD_W-1:0] reply_csum(input logic [WORD_W-1:0] ack,
                                                     input logic [WORD_W-1:0] seq,
                                                     input logic [WORD_W-1:0] flag);
        logic [WORD_W+1:0] t;
        logic [WORD_W:0]   f1;
        logic [WORD_W-1:0] f2;
        t  = {2'b00, ack} + {2'b00, seq} + {2'b00, flag} + {2'b00, TAG_DATA};
        f1 = {1'b0, t[WORD_W-1:0]} + {15'd0, t[WORD_W+1:WORD_W]};
        f2 = f1[WORD_W-1:0] + {15'd0, f1[WORD_W]};
        return ~f2;
    endfunction

endpackage

`default_nettype wire

/* rtl/gbnrc_chan_if.sv */
// valid/ready channel interfaces for packet words and verdicts
// depends on gbnrc_pkg for the payload structs
`default_nettype none

interface gbnrc_pkt_if;
    import gbnrc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbnrc_res_if;
    import gbnrc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/gbnrc_in_stage.sv */
// input register for packet words
// depends on gbnrc_pkg and gbnrc_pkt_if
`default_nettype none

module gbnrc_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    gbnrc_pkt_if.sink            i_pkt,
    input  wire                  i_take,
    output logic                 o_valid,
    output gbnrc_pkg::t_in_item  o_item
);
    import gbnrc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign i_pkt.ready = !r_valid || i_take;
    assign w_load      = i_pkt.valid && i_pkt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_pkt.data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

`default_nettype wire

/* rtl/gbnrc_out_stage.sv */
// output register holding one verdict transaction
// depends on gbnrc_pkg and gbnrc_res_if
`default_nettype none

module gbnrc_out_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  gbnrc_pkg::t_out_item i_item,
    output logic                 o_free,
    gbnrc_res_if.source          o_res
);
    import gbnrc_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_item;
endmodule

`default_nettype wire

/* rtl/gbnrc_core.sv */
// per-word checksum, header capture, sequence tracking and verdict logic
// depends on gbnrc_pkg
`default_nettype none

module gbnrc_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  gbnrc_pkg::t_in_item   i_item,
    input  wire                   i_out_free,
    output logic                  o_take,
    output logic                  o_res_valid,
    output gbnrc_pkg::t_out_item  o_res_item
);
    import gbnrc_pkg::*;

    logic [WORD_W-1:0] r_sum;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_hdr [HEADER_WORDS];
    logic [WORD_W-1:0] r_exp_seq;
    logic              r_closed;

    logic [WORD_W-1:0] n_sum;
    logic [POS_W-1:0]  n_pos;
    logic [WORD_W-1:0] n_exp_seq;
    logic              n_closed;

    logic [WORD_W-1:0] w_sum_word;
    logic [WORD_W-1:0] w_hdr [HEADER_WORDS];
    logic              w_hdr_wr;
    logic [WORD_W-1:0] w_ack;
    logic [WORD_W-1:0] w_seq;
    logic [WORD_W-1:0] w_flag;
    t_out_item         w_res;

    // a last word needs room in the output register, other words never stall
    assign o_take      = i_valid && (!i_item.last || i_out_free);
    assign o_res_valid = o_take && i_item.last;

    assign w_sum_word = oc_add(r_sum, i_item.word);
    assign w_hdr_wr   = !r_closed && (r_pos < POS_W'(HEADER_WORDS));

    // header as seen including the current word
    always_comb begin
        for (int i = 0; i < HEADER_WORDS; i++) begin
            w_hdr[i] = (w_hdr_wr && r_pos == POS_W'(i)) ? i_item.word : r_hdr[i];
        end
    end

    always_comb begin
        w_res         = '0;
        w_res.verdict = VERDICT_ACCEPT;
        w_ack         = w_hdr[HDR_ACK] + 16'd1;
        w_seq         = r_exp_seq;
        w_flag        = w_hdr[HDR_FLAGS];
        n_exp_seq     = r_exp_seq;
        n_closed      = r_closed;

        priority if (r_closed) begin
            w_res.verdict = VERDICT_CLOSED;
        end else if (w_sum_word != SUM_GOOD) begin
            w_res.verdict = VERDICT_CSUM_ERR;
            n_closed      = 1'b1;
        end else if (w_hdr[HDR_TAG] != TAG_DATA) begin
            w_res.verdict = VERDICT_NOT_DATA;
        end else if (w_hdr[HDR_ACK] == r_exp_seq) begin
            w_res.verdict        = VERDICT_ACCEPT;
            w_res.send_reply     = 1'b1;
            w_res.payload_length = w_hdr[HDR_LEN];
            w_res.transfer_done  = (w_hdr[HDR_FLAGS] == FLAG_END);
            n_exp_seq            = w_ack;
            n_closed             = (w_hdr[HDR_FLAGS] == FLAG_END);
        end else begin
            w_res.verdict    = VERDICT_OOO;
            w_res.send_reply = 1'b1;
            w_ack            = r_exp_seq - 16'd1;
            w_seq            = w_hdr[HDR_SEQ];
            w_flag           = FLAG_RESEND;
        end

        if (w_res.send_reply) begin
            w_res.reply_ack      = w_ack;
            w_res.reply_seq      = w_seq;
            w_res.reply_flag     = w_flag;
            w_res.reply_checksum = reply_csum(w_ack, w_seq, w_flag);
        end
    end

    assign o_res_item = w_res;

    always_comb begin
        n_sum = r_closed ? r_sum : w_sum_word;
        n_pos = w_hdr_wr ? (r_pos + POS_W'(1)) : r_pos;
        if (i_item.last) begin
            n_sum = '0;
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_pos     <= '0;
            r_exp_seq <= '0;
            r_closed  <= 1'b0;
        end else if (o_take) begin
            r_sum <= n_sum;
            r_pos <= n_pos;
            if (i_item.last) begin
                r_exp_seq <= n_exp_seq;
                r_closed  <= n_closed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_hdr_wr) begin
            r_hdr[r_pos] <= i_item.word;
        end
    end

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("receiver reopened without reset");

    a_seq_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_exp_seq)) |->
            $past(o_res_valid && (o_res_item.verdict == VERDICT_ACCEPT)))
        else $error("expected sequence moved without an accepted packet");

    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0) && (r_sum == '0))
        else $error("packet state not cleared after verdict");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_item.transfer_done) |=> r_closed)
        else $error("end of transfer did not close the receiver");
endmodule

`default_nettype wire

/* rtl/go_back_n_receiver_checksum.sv */
// go-back-n receiver top level: input register, verdict core, output register
// depends on gbnrc_pkg, gbnrc_chan_if, gbnrc_in_stage, gbnrc_core, gbnrc_out_stage
//
// usage
//   i_pkt carries one 16-bit packet word per transaction, header words first
//   (ack, seq, length, checksum, flags, tag), last marks the final word
//   o_res carries one verdict transaction per packet, built on its last word:
//   verdict, reply header fields with reply checksum, send flag, payload
//   length and end-of-transfer flag
//   verdicts go to the output register behind o_res; throughput is one word
//   per cycle while no last word waits for that register, each word taking one
//   end-around-carry add plus header capture between the two registers
//   reset clears the running sum, word position, expected sequence (zero)
//   and the closed flag; header words are not cleared and hold whatever the
//   previous packets left
//   when o_res stalls, non-last words keep streaming into the checksum; a
//   last word waits in the input register until the output register frees,
//   and i_pkt.ready drops only then
//   after a checksum error or an accepted end packet the receiver is closed:
//   words are ignored and each packet end gives a closed verdict, no reply
`default_nettype none

module go_back_n_receiver_checksum (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gbnrc_pkt_if.sink    i_pkt,
    gbnrc_res_if.source  o_res
);
    import gbnrc_pkg::*;

    // word held in the input register
    logic      w_in_valid;
    t_in_item  w_in_item;
    // core to output register
    logic      w_take;
    logic      w_res_valid;
    t_out_item w_res_item;
    logic      w_out_free;

    gbnrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    // checksum, header capture and verdict in one pass per word
    gbnrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_item      (w_in_item),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item)
    );

    // result held here so the input side keeps moving while o_res stalls
    gbnrc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_item  (w_res_item),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );
endmodule

`default_nettype wire
